[hw/rtl/spq_pkg.sv]
// shared types and codes for the sorted priority queue
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam logic [1:0] CMD_ENQ   = 2'd0;
  localparam logic [1:0] CMD_DEQ   = 2'd1;
  localparam logic [1:0] CMD_PEEK  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_NULL      = 2'd2;
  localparam logic [1:0] ST_UNDERFLOW = 2'd3;

  localparam logic [4:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic ins;  // enqueue accepted this cycle
    logic pop;  // dequeue of a stored entry this cycle
  } spq_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/spq_cell.sv]
// one slot of the sorted array: compare against the new entry and shift
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
  parameter int PW = 32
) (
  input  wire logic              clk,
  input  spq_pkg::spq_ctl_t      ctl,
  input  wire logic [PW-1:0]     new_pay,
  input  wire logic signed [31:0] new_pri,
  input  wire logic [PW-1:0]     left_pay,
  input  wire logic signed [31:0] left_pri,
  input  wire logic              left_keep,
  input  wire logic [PW-1:0]     right_pay,
  input  wire logic signed [31:0] right_pri,
  input  wire logic              occ,
  output logic [PW-1:0]          pay,
  output logic signed [31:0]     pri,
  output logic                   keep
);
  import spq_pkg::*;

  // equal priorities stay ahead of the new entry
  assign keep = occ && (pri >= new_pri);

  always_ff @(posedge clk) begin
    if (ctl.ins && !keep) begin
      if (left_keep) begin
        pay <= new_pay;
        pri <= new_pri;
      end else begin
        pay <= left_pay;
        pri <= left_pri;
      end
    end else if (ctl.pop) begin
      pay <= right_pay;
      pri <= right_pri;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sorted_priority_queue.sv]
// sorted priority queue: a row of compare-and-shift cells, highest priority at cell 0
// an accepted command's result enters the output register in the next cycle
// one command per cycle unless stalled; every cell compares and shifts in parallel
// the output register holds a result until taken and input is stalled meanwhile
// reset clears the entry count and sets the capacity to 16; slot contents stay undefined
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // payload[31:0], priority_req[63:32]
  input  wire logic [1:0]  s_tuser,   // command[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // out_payload[31:0], out_priority[63:32], is_full[64],
                                      // is_empty[65], entry_count[70:66], zero[71]
  output logic [2:0]       m_tuser,   // status[1:0], out_valid[2]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data
);
  import spq_pkg::*;

  localparam int PW = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [4:0]      cap;
  logic            accept;
  logic [1:0]      cmd;
  logic [PW-1:0]   in_pay;
  logic signed [31:0] in_pri;
  spq_ctl_t        ctl;
  logic [1:0]      status_next;
  logic            ovalid_next;
  logic            full_now;

  logic [PW-1:0]      cell_pay  [DEPTH];
  logic signed [31:0] cell_pri  [DEPTH];
  logic               cell_keep [DEPTH];

  function automatic logic full_of(input logic [CW-1:0] n, input logic [4:0] c);
    full_of = (32'(n) >= 32'(DEPTH)) || (32'(n) >= 32'(c));
  endfunction

  assign s_tready  = !rst && (!m_tvalid || m_tready);
  assign cfg_ready = !rst;
  assign accept    = s_tvalid && s_tready;
  assign cmd       = s_tuser;
  assign in_pay    = s_tdata[PW-1:0];
  assign in_pri    = s_tdata[63:32];
  assign full_now  = full_of(count, cap);

  always_comb begin
    status_next = ST_OK;
    ovalid_next = 1'b0;
    count_next  = count;
    ctl.ins     = 1'b0;
    ctl.pop     = 1'b0;
    case (cmd)
      CMD_ENQ: begin
        if (full_now) begin
          status_next = ST_OVERFLOW;
        end else if (in_pay == '0) begin
          status_next = ST_NULL;
        end else begin
          ctl.ins    = accept;
          count_next = count + 1'b1;
        end
      end
      CMD_DEQ, CMD_PEEK: begin
        if (count == '0) begin
          status_next = ST_UNDERFLOW;
        end else begin
          ovalid_next = 1'b1;
          if (cmd == CMD_DEQ) begin
            ctl.pop    = accept;
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
        if (count == '0) begin
          status_next = ST_UNDERFLOW;
        end else begin
          count_next = '0;
        end
      end
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [PW-1:0]      l_pay;
      logic signed [31:0] l_pri;
      logic               l_keep;
      logic [PW-1:0]      r_pay;
      logic signed [31:0] r_pri;

      if (g == 0) begin : g_first
        // the head cell takes the new entry whenever it does not keep its own
        assign l_pay  = in_pay;
        assign l_pri  = in_pri;
        assign l_keep = 1'b1;
      end else begin : g_mid
        assign l_pay  = cell_pay[g-1];
        assign l_pri  = cell_pri[g-1];
        assign l_keep = cell_keep[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
        assign r_pay = cell_pay[g];
        assign r_pri = cell_pri[g];
      end else begin : g_inner
        assign r_pay = cell_pay[g+1];
        assign r_pri = cell_pri[g+1];
      end

      spq_cell #(.PW(PW)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .new_pay   (in_pay),
        .new_pri   (in_pri),
        .left_pay  (l_pay),
        .left_pri  (l_pri),
        .left_keep (l_keep),
        .right_pay (r_pay),
        .right_pri (r_pri),
        .occ       (CW'(g) < count),
        .pay       (cell_pay[g]),
        .pri       (cell_pri[g]),
        .keep      (cell_keep[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cap   <= CAP_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap <= cfg_data;
      end
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser       <= {ovalid_next, status_next};
      m_tdata[31:0] <= ovalid_next ? 32'(cell_pay[0]) : 32'd0;
      m_tdata[63:32] <= ovalid_next ? cell_pri[0] : 32'sd0;
      m_tdata[64]   <= full_of(count_next, cap);
      m_tdata[65]   <= (count_next == '0);
      m_tdata[70:66] <= 5'(count_next);
      m_tdata[71]   <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/spq_checker.sv]
// port-level checks for the sorted priority queue
`timescale 1ns / 1ps
`default_nettype none

module spq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [63:0] s_tdata,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata,
  input wire logic [2:0]  m_tuser
);
  import spq_pkg::*;

  // every accepted item yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item produced no result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[65] == (m_tdata[70:66] == 5'd0)))
    else $error("empty flag disagrees with count");

  // a front entry is only reported with ok status and a nonzero payload
  a_front_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1:0] == ST_OK && m_tdata[31:0] != 32'd0)
    else $error("front entry with bad status or null payload");

  // a successful enqueue leaves the queue nonempty
  a_enq_nonempty: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_ENQ && s_tdata[31:0] != 32'd0
      |=> m_tuser[1:0] == ST_OVERFLOW || !m_tdata[65])
    else $error("queue empty after successful enqueue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire
